// ===== design/vus_pkg.sv =====
`default_nettype none

package vus_pkg;

    localparam int TAG_W      = 16;
    localparam int ACT_W      = 2;
    localparam int RUN_W      = 12;
    localparam int LEN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    // command word: a tag for a pass, or {count, first position} for a burst
    localparam int WORD_W     = 16;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_SILENCE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SPEECH  = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FRAMES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES   = 2'd2;

    localparam logic [RUN_W-1:0] START_FRAMES_RST = 12'd15;
    localparam logic [RUN_W-1:0] END_FRAMES_RST   = 12'd35;
    localparam logic [LEN_W-1:0] MAX_FRAMES_RST   = 16'd3000;

    typedef enum logic {
        CMD_PASS,
        CMD_BURST
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               sent_end;
        logic [WORD_W-1:0]  word;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/vus_cmd_fifo.sv =====
`default_nettype none

module vus_cmd_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  vus_pkg::t_cmd   i_cmd,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_valid,
    output vus_pkg::t_cmd   o_cmd
);

    vus_pkg::t_cmd r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;
    logic          n_wr;
    logic          n_rd;
    logic [1:0]    n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = do_push ? ~r_wr : r_wr;
        n_rd    = do_pop ? ~r_rd : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/vus_front.sv =====
`default_nettype none

module vus_front #(
    parameter int PREROLL_FRAMES = 25,
    localparam int POS_W = (PREROLL_FRAMES > 1) ? $clog2(PREROLL_FRAMES) : 1,
    localparam int CNT_W = $clog2(PREROLL_FRAMES + 1)
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [vus_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [vus_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire [vus_pkg::TAG_W-1:0]       i_tag,
    input  wire [vus_pkg::ACT_W-1:0]       i_activity,
    input  wire                            i_speaking,
    input  wire                            i_restart,
    input  wire                            i_fifo_full,
    output logic                           o_push,
    output vus_pkg::t_cmd                  o_cmd,
    input  wire                            i_burst_done,
    output logic                           o_ring_we,
    output logic [POS_W-1:0]               o_ring_addr,
    output logic [vus_pkg::TAG_W-1:0]      o_ring_data
);

    logic [vus_pkg::RUN_W-1:0] r_start_frames, n_start_frames;
    logic [vus_pkg::RUN_W-1:0] r_end_frames,   n_end_frames;
    logic [vus_pkg::LEN_W-1:0] r_max_frames,   n_max_frames;
    logic                      r_in_sentence,  n_in_sentence;
    logic [POS_W-1:0]          r_wpos,         n_wpos;
    logic [CNT_W-1:0]          r_fill,         n_fill;
    logic [vus_pkg::RUN_W-1:0] r_voice_run,    n_voice_run;
    logic [vus_pkg::RUN_W-1:0] r_quiet_run,    n_quiet_run;
    logic [vus_pkg::LEN_W-1:0] r_utter_len,    n_utter_len;
    logic                      r_burst_busy,   n_burst_busy;

    logic             accept;
    logic             cand;
    logic [CNT_W-1:0] wpos_ext;
    logic [POS_W-1:0] first;

    // waiting frames write the ring, so they hold off while a burst replays it
    assign o_ready = !i_fifo_full && !(!r_in_sentence && r_burst_busy);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_start_frames = r_start_frames;
        n_end_frames   = r_end_frames;
        n_max_frames   = r_max_frames;
        n_in_sentence  = r_in_sentence;
        n_wpos         = r_wpos;
        n_fill         = r_fill;
        n_voice_run    = r_voice_run;
        n_quiet_run    = r_quiet_run;
        n_utter_len    = r_utter_len;
        n_burst_busy   = i_burst_done ? 1'b0 : r_burst_busy;
        o_push         = 1'b0;
        o_cmd          = '{kind: vus_pkg::CMD_PASS, sent_end: 1'b0, word: i_tag};
        o_ring_we      = 1'b0;
        o_ring_addr    = r_wpos;
        o_ring_data    = i_tag;
        cand           = 1'b0;
        wpos_ext       = '0;
        first          = '0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                vus_pkg::CFG_START_FRAMES: n_start_frames = i_cfg_data[vus_pkg::RUN_W-1:0];
                vus_pkg::CFG_END_FRAMES:   n_end_frames   = i_cfg_data[vus_pkg::RUN_W-1:0];
                vus_pkg::CFG_MAX_FRAMES:   n_max_frames   = i_cfg_data[vus_pkg::LEN_W-1:0];
                default: ;
            endcase
        end

        if (accept) begin
            if (i_restart) begin
                n_in_sentence = 1'b0;
                n_wpos        = '0;
                n_fill        = '0;
                n_voice_run   = '0;
                n_quiet_run   = '0;
                n_utter_len   = '0;
            end else if (r_in_sentence) begin
                if (i_activity != vus_pkg::ACT_SILENCE) begin
                    n_quiet_run = '0;
                end else if (r_quiet_run != vus_pkg::RUN_MAX) begin
                    n_quiet_run = r_quiet_run + 1'b1;
                end
                if (r_utter_len != vus_pkg::LEN_MAX) begin
                    n_utter_len = r_utter_len + 1'b1;
                end
                o_push         = 1'b1;
                o_cmd.sent_end = (n_utter_len >= r_max_frames) ||
                                 (n_quiet_run >= r_end_frames);
            end else begin
                o_ring_we = 1'b1;
                n_wpos    = (r_wpos == POS_W'(PREROLL_FRAMES - 1)) ? '0 : r_wpos + 1'b1;
                if (r_fill < CNT_W'(PREROLL_FRAMES)) begin
                    n_fill = r_fill + 1'b1;
                end
                cand = i_speaking ? (i_activity == vus_pkg::ACT_SPEECH)
                                  : (i_activity != vus_pkg::ACT_SILENCE);
                if (!cand) begin
                    n_voice_run = '0;
                end else if (r_voice_run != vus_pkg::RUN_MAX) begin
                    n_voice_run = r_voice_run + 1'b1;
                end
                // oldest entry sits fill positions behind the write pointer
                wpos_ext = CNT_W'(n_wpos);
                if (wpos_ext >= n_fill) begin
                    first = POS_W'(wpos_ext - n_fill);
                end else begin
                    first = POS_W'(CNT_W'(PREROLL_FRAMES) - (n_fill - wpos_ext));
                end
                if (n_voice_run >= r_start_frames) begin
                    n_in_sentence = 1'b1;
                    n_utter_len   = vus_pkg::LEN_W'(n_fill);
                    n_burst_busy  = 1'b1;
                    o_push        = 1'b1;
                    o_cmd.kind    = vus_pkg::CMD_BURST;
                    o_cmd.word    = vus_pkg::WORD_W'({n_fill, first});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_frames <= vus_pkg::START_FRAMES_RST;
            r_end_frames   <= vus_pkg::END_FRAMES_RST;
            r_max_frames   <= vus_pkg::MAX_FRAMES_RST;
            r_in_sentence  <= 1'b0;
            r_wpos         <= '0;
            r_fill         <= '0;
            r_voice_run    <= '0;
            r_quiet_run    <= '0;
            r_utter_len    <= '0;
            r_burst_busy   <= 1'b0;
        end else begin
            r_start_frames <= n_start_frames;
            r_end_frames   <= n_end_frames;
            r_max_frames   <= n_max_frames;
            r_in_sentence  <= n_in_sentence;
            r_wpos         <= n_wpos;
            r_fill         <= n_fill;
            r_voice_run    <= n_voice_run;
            r_quiet_run    <= n_quiet_run;
            r_utter_len    <= n_utter_len;
            r_burst_busy   <= n_burst_busy;
        end
    end

endmodule

`default_nettype wire

// ===== design/vus_back.sv =====
`default_nettype none

module vus_back #(
    parameter int PREROLL_FRAMES = 25,
    localparam int POS_W = (PREROLL_FRAMES > 1) ? $clog2(PREROLL_FRAMES) : 1,
    localparam int CNT_W = $clog2(PREROLL_FRAMES + 1)
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_fifo_valid,
    input  vus_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_burst_done,
    input  wire                        i_ring_we,
    input  wire [POS_W-1:0]            i_ring_addr,
    input  wire [vus_pkg::TAG_W-1:0]   i_ring_data,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [vus_pkg::TAG_W-1:0]  o_tag,
    output logic                       o_sent_start,
    output logic                       o_sent_end,
    output logic                       o_last
);

    logic [vus_pkg::TAG_W-1:0] r_ring [PREROLL_FRAMES];
    logic [vus_pkg::TAG_W-1:0] r_rd_data;

    vus_pkg::t_back_state r_state, n_state;
    logic [POS_W-1:0]     r_pos,   n_pos;
    logic [CNT_W-1:0]     r_left,  n_left;

    logic                      r_out_valid, n_out_valid;
    logic [vus_pkg::TAG_W-1:0] r_out_tag,   n_out_tag;
    logic                      r_out_start, n_out_start;
    logic                      r_out_end,   n_out_end;
    logic                      r_out_last,  n_out_last;

    logic             slot_free;
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] cmd_first;
    logic [CNT_W-1:0] cmd_count;

    assign slot_free = !r_out_valid || i_ready;
    assign pos_inc   = (r_pos == POS_W'(PREROLL_FRAMES - 1)) ? '0 : r_pos + 1'b1;
    assign cmd_first = i_cmd.word[POS_W-1:0];
    assign cmd_count = i_cmd.word[POS_W +: CNT_W];

    assign o_valid      = r_out_valid;
    assign o_tag        = r_out_tag;
    assign o_sent_start = r_out_start;
    assign o_sent_end   = r_out_end;
    assign o_last       = r_out_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            vus_pkg::BK_IDLE: begin
                if (i_fifo_valid && i_cmd.kind == vus_pkg::CMD_BURST) begin
                    n_state = vus_pkg::BK_BURST;
                end
            end
            vus_pkg::BK_BURST: begin
                if (slot_free && r_left == CNT_W'(1)) begin
                    n_state = vus_pkg::BK_IDLE;
                end
            end
            default: n_state = vus_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        o_burst_done = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_pos;
        n_pos        = r_pos;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_tag    = r_out_tag;
        n_out_start  = r_out_start;
        n_out_end    = r_out_end;
        n_out_last   = r_out_last;
        case (r_state)
            vus_pkg::BK_IDLE: begin
                if (i_fifo_valid) begin
                    if (i_cmd.kind == vus_pkg::CMD_BURST) begin
                        // fetch the oldest tag, it lands in the read register next cycle
                        o_pop   = 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = cmd_first;
                        n_pos   = cmd_first;
                        n_left  = cmd_count;
                    end else if (slot_free) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_tag   = i_cmd.word[vus_pkg::TAG_W-1:0];
                        n_out_start = 1'b0;
                        n_out_end   = i_cmd.sent_end;
                        n_out_last  = 1'b1;
                    end
                end
            end
            vus_pkg::BK_BURST: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_tag   = r_rd_data;
                    n_out_start = 1'b1;
                    n_out_end   = 1'b0;
                    n_out_last  = (r_left == CNT_W'(1));
                    if (r_left == CNT_W'(1)) begin
                        o_burst_done = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_inc;
                        n_pos   = pos_inc;
                        n_left  = r_left - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vus_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_tag   <= n_out_tag;
        r_out_start <= n_out_start;
        r_out_end   <= n_out_end;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_ring_we) begin
            r_ring[i_ring_addr] <= i_ring_data;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/vad_utterance_segmenter.sv =====
// a sentence frame reaches the output through the command queue and the output register
// throughput: one frame per cycle while in sentence or waiting without a start, when not stalled
// a start burst of n ring entries (n = frames stored, at most PREROLL_FRAMES)
//   is replayed oldest first by the back end through the registered ring read
// reset: synchronous active low, clears phase, counters, queue and output valid,
//   loads register defaults; ring contents stay undefined until written
`default_nettype none

module vad_utterance_segmenter #(
    parameter int PREROLL_FRAMES = 25,
    localparam int POS_W = (PREROLL_FRAMES > 1) ? $clog2(PREROLL_FRAMES) : 1
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration write port
    input  wire                            i_cfg_we,
    input  wire [vus_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [vus_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // frame descriptor stream
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [15:0]                     s_axis_tdata,  // [15:0] frame_tag
    input  wire [3:0]                      s_axis_tuser,  // [1:0] activity, [2] speaking, [3] restart
    // delivered frame stream
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [15:0]                    m_axis_tdata,  // [15:0] out_tag
    output logic [1:0]                     m_axis_tuser,  // [0] sentence_start, [1] sentence_end
    output logic                           m_axis_tlast
);

    // front to back command queue
    logic          cmd_push;
    vus_pkg::t_cmd cmd_in;
    logic          cmd_pop;
    logic          cmd_full;
    logic          cmd_valid;
    vus_pkg::t_cmd cmd_out;

    // back end tells the front when the ring is free again
    logic burst_done;

    // ring write port driven by the front end while waiting
    logic                      ring_we;
    logic [POS_W-1:0]          ring_addr;
    logic [vus_pkg::TAG_W-1:0] ring_data;

    logic sent_start;
    logic sent_end;

    // front: config registers, counters, phase; decides pass or burst per frame
    vus_front #(
        .PREROLL_FRAMES (PREROLL_FRAMES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_tag        (s_axis_tdata),
        .i_activity   (s_axis_tuser[1:0]),
        .i_speaking   (s_axis_tuser[2]),
        .i_restart    (s_axis_tuser[3]),
        .i_fifo_full  (cmd_full),
        .o_push       (cmd_push),
        .o_cmd        (cmd_in),
        .i_burst_done (burst_done),
        .o_ring_we    (ring_we),
        .o_ring_addr  (ring_addr),
        .o_ring_data  (ring_data)
    );

    // two-entry queue so either side can stall on its own
    vus_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    // back: holds the pre-roll ring, replays bursts, drives the output register
    vus_back #(
        .PREROLL_FRAMES (PREROLL_FRAMES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (cmd_valid),
        .i_cmd        (cmd_out),
        .o_pop        (cmd_pop),
        .o_burst_done (burst_done),
        .i_ring_we    (ring_we),
        .i_ring_addr  (ring_addr),
        .i_ring_data  (ring_data),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_tag        (m_axis_tdata),
        .o_sent_start (sent_start),
        .o_sent_end   (sent_end),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tuser = {sent_end, sent_start};

endmodule

`default_nettype wire

// ===== test/vad_utterance_segmenter_tb.sv =====
`default_nettype none

module vad_utterance_segmenter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import vus_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RING_DEPTH  = 25;
    // cycles with no transaction on either side before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // settle time after the last expected result before a register write
    localparam int SETTLE_CYCLES = 8;
    // frames in the closing run at the widest end and length thresholds
    localparam int SOAK_QUIET  = 6;
    localparam int SOAK_VOICE  = 4;

    // one delivered frame as seen on the master side
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             sstart;
        logic             send;
        logic             last;
    } t_delivered;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,  // expectation comes from the segmenter model below
        CHK_SILENT,   // no transaction may come out for this frame
        CHK_PASS      // one pass-through transaction with the given end flag
    } t_row_chk;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [ACT_W-1:0] act;
        logic             spk;
        logic             rst;
        t_row_chk         chk;
        logic             end_flag;
    } t_stim_row;

    // shapes of random stimulus segments
    typedef enum logic [1:0] {
        SEG_VOICE,
        SEG_QUIET,
        SEG_NOISE,
        SEG_RESTART
    } t_seg_kind;

    localparam logic [ACT_W-1:0] ACT_OTHER = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CODE3 = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_START_FRAMES;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // [15:0] frame_tag
    logic [3:0]            s_axis_tuser = '0;   // [1:0] activity, [2] speaking, [3] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;        // [15:0] out_tag
    logic [1:0]            m_axis_tuser;        // [0] sentence_start, [1] sentence_end
    logic                  m_axis_tlast;

    vad_utterance_segmenter #(
        .PREROLL_FRAMES(RING_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // segmenter model: thresholds, phase, pre-roll ring and counters
    // ------------------------------------------------------------------
    logic [RUN_W-1:0] cfg_start = START_FRAMES_RST;
    logic [RUN_W-1:0] cfg_end   = END_FRAMES_RST;
    logic [LEN_W-1:0] cfg_max   = MAX_FRAMES_RST;

    logic             seg_active = 1'b0;
    logic [TAG_W-1:0] tag_ring [RING_DEPTH];
    int               ring_wr = 0;
    int               ring_fill = 0;
    logic [RUN_W-1:0] cand_run = '0;
    logic [RUN_W-1:0] silent_run = '0;
    logic [LEN_W-1:0] utt_frames = '0;

    // frames released by the last modeled input, in delivery order
    t_delivered       release_buf [RING_DEPTH];
    int               release_n = 0;

    // delivered frames still owed by the block, oldest first
    t_delivered       deliveries_due [$];

    int               mismatch_count = 0;
    int               quiet_cycles = 0;
    int               src_idle_pct = 0;
    int               snk_idle_pct = 0;

    // random segment generator state
    t_seg_kind        seg_kind = SEG_QUIET;
    int               seg_left = 0;

    function automatic void clear_segmenter();
        seg_active = 1'b0;
        ring_wr    = 0;
        ring_fill  = 0;
        cand_run   = '0;
        silent_run = '0;
        utt_frames = '0;
    endfunction

    // one frame descriptor through the model; fills release_buf
    function automatic void segment_frame(input logic [TAG_W-1:0] tag,
                                          input logic [ACT_W-1:0] act,
                                          input logic spk, input logic rst);
        logic cand;
        int   first;
        release_n = 0;
        if (rst) begin
            // discontinuity wins over everything, thresholds are kept
            clear_segmenter();
            return;
        end
        if (seg_active) begin
            if (act != ACT_SILENCE)
                silent_run = '0;
            else if (silent_run != RUN_MAX)
                silent_run = silent_run + 1'b1;
            if (utt_frames != LEN_MAX)
                utt_frames = utt_frames + 1'b1;
            release_buf[0] = {tag, 1'b0,
                              (utt_frames >= cfg_max) || (silent_run >= cfg_end), 1'b1};
            release_n = 1;
            return;
        end
        tag_ring[ring_wr] = tag;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH)
            ring_fill++;
        // during playback only real speech counts, otherwise any non-silence
        cand = spk ? (act == ACT_SPEECH) : (act != ACT_SILENCE);
        if (!cand)
            cand_run = '0;
        else if (cand_run != RUN_MAX)
            cand_run = cand_run + 1'b1;
        if (cand_run >= cfg_start) begin
            // replay the ring oldest first, current frame last
            first = (ring_wr + RING_DEPTH - ring_fill) % RING_DEPTH;
            seg_active = 1'b1;
            utt_frames = LEN_W'(ring_fill);
            for (int k = 0; k < ring_fill; k++)
                release_buf[k] = {tag_ring[(first + k) % RING_DEPTH], 1'b1, 1'b0,
                                  k == ring_fill - 1};
            release_n = ring_fill;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got_v,
                 want_v);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // master side: random backpressure, result checking, hang watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_delivered got;
        t_delivered want;
        m_axis_tready <= (snk_idle_pct == 0) || ($urandom_range(0, 99) >= snk_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
            if (deliveries_due.size() == 0) begin
                report_mismatch("transaction with nothing owed, tag", got.tag, 0);
            end else begin
                want = deliveries_due.pop_front();
                if (got.tag !== want.tag)
                    report_mismatch("out_tag", got.tag, want.tag);
                if (got.sstart !== want.sstart)
                    report_mismatch("sentence_start", got.sstart, want.sstart);
                if (got.send !== want.send)
                    report_mismatch("sentence_end", got.send, want.send);
                if (got.last !== want.last)
                    report_mismatch("tlast", got.last, want.last);
            end
        end
        // any transaction on either side proves the block is alive
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("vad_utterance_segmenter_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // slave side driver
    // ------------------------------------------------------------------

    // present one frame, hold it until taken, then book what it should release
    task automatic send_frame(input logic [TAG_W-1:0] tag, input logic [ACT_W-1:0] act,
                              input logic spk, input logic rst,
                              input t_row_chk chk, input logic end_flag);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tag;
        s_axis_tuser  <= {rst, spk, act};
        do
            @(posedge i_clk);
        while (s_axis_tready !== 1'b1);
        segment_frame(tag, act, spk, rst);
        case (chk)
            CHK_PREDICT: begin
                for (int k = 0; k < release_n; k++)
                    deliveries_due.push_back(release_buf[k]);
            end
            CHK_PASS: begin
                deliveries_due.push_back({tag, 1'b0, end_flag, 1'b1});
            end
            default: begin
            end
        endcase
    endtask

    // hold off the sender until every owed frame has come out
    task automatic drain_deliveries();
        s_axis_tvalid <= 1'b0;
        while (deliveries_due.size() != 0)
            @(posedge i_clk);
    endtask

    // registers change only with the block idle; frames without output may
    // still be in flight, so let them settle first
    task automatic set_thresholds(input logic [RUN_W-1:0] start_n,
                                  input logic [RUN_W-1:0] end_n,
                                  input logic [LEN_W-1:0] max_n);
        drain_deliveries();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_FRAMES;
        i_cfg_data  <= CFG_DATA_W'(start_n);
        @(posedge i_clk);
        i_cfg_index <= CFG_END_FRAMES;
        i_cfg_data  <= CFG_DATA_W'(end_n);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_FRAMES;
        i_cfg_data  <= max_n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_start = start_n;
        cfg_end   = end_n;
        cfg_max   = max_n;
    endtask

    // random frames built from segments: voice runs of up to the start threshold plus three,
    // quiet runs of up to the end threshold plus three, both capped at 40, some noise and restarts
    task automatic next_random_frame(output logic [TAG_W-1:0] tag,
                                     output logic [ACT_W-1:0] act,
                                     output logic spk, output logic rst);
        int pick;
        int span;
        if (seg_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                seg_kind = SEG_VOICE;
                span = int'(cfg_start) + 3;
            end else if (pick < 75) begin
                seg_kind = SEG_QUIET;
                span = int'(cfg_end) + 3;
            end else if (pick < 88) begin
                seg_kind = SEG_NOISE;
                span = 8;
            end else begin
                seg_kind = SEG_RESTART;
                span = 1;
            end
            if (span > 40)
                span = 40;
            seg_left = $urandom_range(1, span);
        end
        seg_left--;
        tag = TAG_W'($urandom_range(0, 65535));
        rst = 1'b0;
        case (seg_kind)
            SEG_VOICE: begin
                act = ACT_W'($urandom_range(1, 3));
                // playback breaks a run of non-speech now and then
                spk = (act == ACT_SPEECH) ? 1'($urandom_range(0, 1))
                                          : ($urandom_range(0, 9) == 0);
            end
            SEG_QUIET: begin
                act = ($urandom_range(0, 9) < 8) ? ACT_SILENCE : ACT_W'($urandom_range(1, 3));
                spk = 1'($urandom_range(0, 1));
            end
            SEG_NOISE: begin
                act = ACT_W'($urandom_range(0, 3));
                spk = 1'($urandom_range(0, 1));
                rst = ($urandom_range(0, 19) == 0);
            end
            default: begin
                act = ACT_W'($urandom_range(0, 3));
                spk = 1'($urandom_range(0, 1));
                rst = 1'b1;
            end
        endcase
    endtask

    task automatic run_random(input int n_frames);
        logic [TAG_W-1:0] tag;
        logic [ACT_W-1:0] act;
        logic             spk;
        logic             rst;
        for (int i = 0; i < n_frames; i++) begin
            next_random_frame(tag, act, spk, rst);
            send_frame(tag, act, spk, rst, CHK_PREDICT, 1'b0);
        end
    endtask

    // directed frames, run with start 3, end 2, max 6
    t_stim_row directed_rows [18] = '{
        // waiting: silence, then other and code three build a run without playback
        '{16'h0000, ACT_SILENCE, 1'b0, 1'b0, CHK_SILENT,  1'b0},
        '{16'hFFFF, ACT_OTHER,   1'b0, 1'b0, CHK_SILENT,  1'b0},
        '{16'h1234, ACT_CODE3,   1'b0, 1'b0, CHK_SILENT,  1'b0},
        // speech under playback completes the run: four-frame start burst
        '{16'h8001, ACT_SPEECH,  1'b1, 1'b0, CHK_PREDICT, 1'b0},
        // in sentence: quiet run of one, then two ends it together with length
        '{16'h5555, ACT_SILENCE, 1'b0, 1'b0, CHK_PASS,    1'b0},
        '{16'hAAAA, ACT_SILENCE, 1'b1, 1'b0, CHK_PASS,    1'b1},
        // speech resets the quiet run, length limit still holds end
        '{16'h0001, ACT_SPEECH,  1'b0, 1'b0, CHK_PASS,    1'b1},
        // restart out of a sentence
        '{16'h7777, ACT_SPEECH,  1'b1, 1'b1, CHK_SILENT,  1'b0},
        // playback: other and code three do not count
        '{16'h0101, ACT_OTHER,   1'b1, 1'b0, CHK_SILENT,  1'b0},
        '{16'h0202, ACT_CODE3,   1'b1, 1'b0, CHK_SILENT,  1'b0},
        '{16'h0303, ACT_SPEECH,  1'b1, 1'b0, CHK_SILENT,  1'b0},
        '{16'h0404, ACT_SPEECH,  1'b0, 1'b0, CHK_SILENT,  1'b0},
        // silence breaks the run
        '{16'h0505, ACT_SILENCE, 1'b0, 1'b0, CHK_SILENT,  1'b0},
        '{16'h0606, ACT_SPEECH,  1'b0, 1'b0, CHK_SILENT,  1'b0},
        '{16'h0707, ACT_SPEECH,  1'b1, 1'b0, CHK_SILENT,  1'b0},
        // third candidate: burst of every frame stored since the restart
        '{16'h0808, ACT_OTHER,   1'b0, 1'b0, CHK_PREDICT, 1'b0},
        // restart right behind the burst, while it may still be replaying
        '{16'h9999, ACT_SILENCE, 1'b0, 1'b1, CHK_SILENT,  1'b0},
        '{16'h0A0A, ACT_CODE3,   1'b0, 1'b0, CHK_SILENT,  1'b0}
    };

    initial begin
        // sender idle odds 13 percent per draw, receiver 72 percent
        src_idle_pct = 13;
        snk_idle_pct = 72;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_thresholds(12'd3, 12'd2, 16'd6);
        foreach (directed_rows[r])
            send_frame(directed_rows[r].tag, directed_rows[r].act, directed_rows[r].spk,
                       directed_rows[r].rst, directed_rows[r].chk,
                       directed_rows[r].end_flag);

        // reset values written back
        set_thresholds(START_FRAMES_RST, END_FRAMES_RST, MAX_FRAMES_RST);
        run_random(100);
        // every threshold at one
        set_thresholds(12'd1, 12'd1, 16'd1);
        run_random(40);

        // swap: sender idle odds 72 percent per draw, receiver 13 percent
        src_idle_pct = 72;
        snk_idle_pct = 13;
        // zero thresholds: any frame starts, every sentence frame ends
        set_thresholds(12'd0, 12'd0, 16'd0);
        run_random(30);
        // top of range: no start can come, the ring keeps wrapping
        set_thresholds(RUN_MAX, RUN_MAX, LEN_MAX);
        run_random(30);
        set_thresholds(12'd2, 12'd5, 16'd20);
        run_random(40);
        // sender holds back until the block has delivered everything
        drain_deliveries();
        run_random(40);

        // no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_thresholds(12'd4, 12'd3, 16'd12);
        run_random(70);

        // closing run at the widest end and length thresholds: a one-frame
        // start, then a quiet stretch and speech that never raise end
        set_thresholds(12'd1, RUN_MAX, LEN_MAX);
        send_frame(TAG_W'($urandom_range(0, 65535)), ACT_SILENCE, 1'b0, 1'b1,
                   CHK_PREDICT, 1'b0);
        send_frame(TAG_W'($urandom_range(0, 65535)), ACT_SPEECH, 1'b0, 1'b0,
                   CHK_PREDICT, 1'b0);
        for (int i = 0; i < SOAK_QUIET; i++)
            send_frame(TAG_W'($urandom_range(0, 65535)), ACT_SILENCE,
                       1'($urandom_range(0, 1)), 1'b0, CHK_PREDICT, 1'b0);
        for (int i = 0; i < SOAK_VOICE; i++)
            send_frame(TAG_W'($urandom_range(0, 65535)), ACT_W'($urandom_range(1, 3)),
                       1'($urandom_range(0, 1)), 1'b0, CHK_PREDICT, 1'b0);

        drain_deliveries();
        // let anything still in the pipe show up as an unexpected transaction
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("vad_utterance_segmenter_tb OK");
        else
            $display("vad_utterance_segmenter_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
